// File: hdl/vpc_pkg.sv
// Shared types and constants of the velocity PI controller.
// Used by vpc_ctrl, vpc_dp and velocity_pi_controller_top; depends on nothing.
`default_nettype none
package vpc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_HZ    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FF_LIMIT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT  = 3'd5;

	localparam logic [23:0] VEL_CLAMP  = 24'd6553600;
	localparam logic [23:0] TWO_PI_Q16 = 24'd411775;
	localparam logic [23:0] US_PER_S   = 24'd1000000;

	typedef enum logic [4:0] {
		OP_NOP, OP_LATCH, OP_MUL_VEL, OP_DIV_RAW, OP_RAW, OP_MUL_CD, OP_MUL_W,
		OP_DIV_ALPHA, OP_MUL_FILT, OP_FILT, OP_STOP, OP_MUL_STEP, OP_DIV_STEP,
		OP_RAMP, OP_MUL_ERR, OP_DIV_INC, OP_NI, OP_MUL_KLO, OP_MUL_KHI, OP_KSUM,
		OP_MUL_PLO, OP_MUL_PHI, OP_PSUM, OP_FF, OP_OUT
	} vpc_op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_BR, ST_V_MUL, ST_V_DIV, ST_V_WAIT, ST_V_RAW, ST_V_MCD, ST_V_MW,
		ST_A_DIV, ST_A_WAIT, ST_V_MF, ST_V_FILT, ST_STOP, ST_R_MUL, ST_R_DIV,
		ST_R_WAIT, ST_R_RAMP, ST_E_MUL, ST_E_DIV, ST_E_WAIT, ST_NI, ST_K_LO, ST_K_HI,
		ST_K_SUM, ST_P_LO, ST_P_HI, ST_P_SUM, ST_FF, ST_FIN
	} vpc_state_t;

	typedef struct packed {
		vpc_op_t op;
		logic    use_old;
	} vpc_cmd_t;

	typedef struct packed {
		logic pos_valid;
		logic stop;
		logic div_done;
		logic cand_ok;
	} vpc_stat_t;

endpackage
`default_nettype wire

// File: hdl/vpc_div.sv
// Unsigned 64 by 34 bit restoring divider, two quotient bits per cycle.
// Depends on nothing; used by vpc_dp.
`default_nettype none
module vpc_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [33:0] divisor,
	output logic             done,
	output logic      [63:0] quot
);
	logic [33:0] rem_q;
	logic [63:0] dd_q;
	logic [33:0] dv_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] r1, r2;
	logic [33:0] rem1, rem2;
	logic        qb1, qb2;

	always_comb begin
		r1   = {rem_q, dd_q[63]};
		qb1  = (r1 >= {1'b0, dv_q});
		rem1 = qb1 ? 34'(r1 - {1'b0, dv_q}) : r1[33:0];
		r2   = {rem1, dd_q[62]};
		qb2  = (r2 >= {1'b0, dv_q});
		rem2 = qb2 ? 34'(r2 - {1'b0, dv_q}) : r2[33:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dd_q  <= dividend;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= rem2;
			dd_q  <= {dd_q[61:0], qb1, qb2};
		end
	end

	assign done = done_q;
	assign quot = dd_q;
endmodule
`default_nettype wire

// File: hdl/vpc_ctrl.sv
// Sequencer of the velocity PI controller: steps the datapath through one item.
// Depends on vpc_pkg.
`default_nettype none
module vpc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	input  wire vpc_pkg::vpc_stat_t stat,
	output vpc_pkg::vpc_cmd_t  cmd
);
	import vpc_pkg::*;

	vpc_state_t state_q, state_d;
	logic       second_q, second_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		second_d    = second_q;
		cmd.op      = OP_NOP;
		cmd.use_old = second_q;
		s_tready    = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LATCH;
					state_d = ST_BR;
				end
			end
			ST_BR: begin
				priority if (stat.pos_valid) state_d = ST_V_MUL;
				else if (stat.stop) state_d = ST_STOP;
				else state_d = ST_R_MUL;
			end
			ST_V_MUL: begin cmd.op = OP_MUL_VEL; state_d = ST_V_DIV; end
			ST_V_DIV: begin cmd.op = OP_DIV_RAW; state_d = ST_V_WAIT; end
			ST_V_WAIT: if (stat.div_done) state_d = ST_V_RAW;
			ST_V_RAW: begin cmd.op = OP_RAW; state_d = ST_V_MCD; end
			ST_V_MCD: begin cmd.op = OP_MUL_CD; state_d = ST_V_MW; end
			ST_V_MW: begin cmd.op = OP_MUL_W; state_d = ST_A_DIV; end
			ST_A_DIV: begin cmd.op = OP_DIV_ALPHA; state_d = ST_A_WAIT; end
			ST_A_WAIT: if (stat.div_done) state_d = ST_V_MF;
			ST_V_MF: begin cmd.op = OP_MUL_FILT; state_d = ST_V_FILT; end
			ST_V_FILT: begin
				cmd.op  = OP_FILT;
				state_d = stat.stop ? ST_STOP : ST_R_MUL;
			end
			ST_STOP: begin cmd.op = OP_STOP; state_d = ST_FIN; end
			ST_R_MUL: begin cmd.op = OP_MUL_STEP; state_d = ST_R_DIV; end
			ST_R_DIV: begin cmd.op = OP_DIV_STEP; state_d = ST_R_WAIT; end
			ST_R_WAIT: if (stat.div_done) state_d = ST_R_RAMP;
			ST_R_RAMP: begin cmd.op = OP_RAMP; state_d = ST_E_MUL; end
			ST_E_MUL: begin cmd.op = OP_MUL_ERR; state_d = ST_E_DIV; end
			ST_E_DIV: begin cmd.op = OP_DIV_INC; state_d = ST_E_WAIT; end
			ST_E_WAIT: if (stat.div_done) state_d = ST_NI;
			ST_NI: begin
				cmd.op   = OP_NI;
				second_d = 1'b0;
				state_d  = ST_K_LO;
			end
			ST_K_LO: begin cmd.op = OP_MUL_KLO; state_d = ST_K_HI; end
			ST_K_HI: begin cmd.op = OP_MUL_KHI; state_d = ST_K_SUM; end
			ST_K_SUM: begin cmd.op = OP_KSUM; state_d = ST_P_LO; end
			ST_P_LO: begin cmd.op = OP_MUL_PLO; state_d = ST_P_HI; end
			ST_P_HI: begin cmd.op = OP_MUL_PHI; state_d = ST_P_SUM; end
			ST_P_SUM: begin
				cmd.op = OP_PSUM;
				// A saturating candidate repeats the PI pass with the old integral.
				if (!second_q && !stat.cand_ok) begin
					second_d = 1'b1;
					state_d  = ST_K_LO;
				end else begin
					state_d = ST_FF;
				end
			end
			ST_FF: begin cmd.op = OP_FF; state_d = ST_FIN; end
			ST_FIN: begin
				if (!out_valid_q || m_tready) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;
endmodule
`default_nettype wire

// File: hdl/vpc_dp.sv
// Datapath of the velocity PI controller: state, configuration registers,
// one shared 32x24 multiplier and the divider. Depends on vpc_pkg and vpc_div.
`default_nettype none
module vpc_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [vpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [vpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           func,
	input  wire logic [31:0]                    measured_position,
	input  wire logic                           position_valid,
	input  wire logic [15:0]                    step_time_us,
	input  wire logic [23:0]                    target_velocity,
	input  wire vpc_pkg::vpc_cmd_t              cmd,
	output vpc_pkg::vpc_stat_t                  stat,
	output logic [23:0]                         drive_current,
	output logic [23:0]                         filtered_velocity,
	output logic                                stop_command,
	output logic [15:0]                         comm_errors
);
	import vpc_pkg::*;

	localparam logic signed [49:0] I_MAX = 50'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [49:0] I_MIN = -50'sh0_8000_0000_0000;
	localparam logic signed [41:0] S_MAX = 42'sh040_0000_0000;

	// Configuration.
	logic [23:0] prop_gain_q, integ_gain_q;
	logic [22:0] output_limit_q, ff_limit_q;
	logic [13:0] cutoff_hz_q;
	logic [30:0] accel_limit_q;

	// Controller state.
	logic signed [31:0] last_q, smooth_q, ramp_q;
	logic signed [47:0] integ_q;
	logic               stopped_q;
	logic        [15:0] errcnt_q;

	// Item and intermediate values.
	logic               func_q, valid_q;
	logic        [31:0] pos_q;
	logic        [15:0] dt_q;
	logic signed [23:0] tgt_q;
	logic signed [32:0] d_q;
	logic signed [23:0] raw_q;
	logic               diff_neg_q;
	logic signed [25:0] err_q;
	logic signed [47:0] ni_q;
	logic        [47:0] plo_q;
	logic               s_neg_q;
	logic        [38:0] s_mag_q;
	logic signed [47:0] cur_q;
	logic        [55:0] prod_q;

	// Multiplier and divider ports.
	logic [31:0] mul_a;
	logic [23:0] mul_b;
	logic        div_start, div_done;
	logic [63:0] div_dividend, div_quot;
	logic [33:0] div_divisor;

	// Combinational terms.
	logic signed [32:0] d_in;
	logic        [31:0] d_mag;
	logic        [22:0] raw_mag;
	logic signed [23:0] raw_d;
	logic        [32:0] w;
	logic signed [24:0] diff;
	logic        [23:0] diff_mag;
	logic        [23:0] delta;
	logic signed [31:0] smooth_d;
	logic signed [33:0] r34, st34, lo34, hi34, t34, ramp_d;
	logic signed [25:0] err_d;
	logic        [24:0] err_mag;
	logic signed [48:0] inc;
	logic signed [49:0] ni_sum, ni_sat;
	logic signed [47:0] x;
	logic        [47:0] x_mag;
	logic        [71:0] k_tot;
	logic signed [41:0] ki, s_raw, s_cl;
	logic        [62:0] p_tot;
	logic        [46:0] p_mag;
	logic signed [47:0] cand;
	logic signed [27:0] ff10, ffl, ff;
	logic signed [48:0] sum49, lim49, cur_d;

	always_comb begin
		d_in     = $signed({measured_position[31], measured_position})
			- $signed({last_q[31], last_q});
		d_mag    = d_q[32] ? 32'(-d_q) : d_q[31:0];
		raw_mag  = (div_quot > {40'b0, VEL_CLAMP}) ? VEL_CLAMP[22:0] : div_quot[22:0];
		raw_d    = d_q[32] ? -$signed({1'b0, raw_mag}) : $signed({1'b0, raw_mag});
		w        = prod_q[48:16];
		diff     = $signed({raw_q[23], raw_q}) - $signed(smooth_q[24:0]);
		diff_mag = diff[24] ? 24'(-diff) : diff[23:0];
		delta    = prod_q[47:24];
		smooth_d = diff_neg_q ? smooth_q - $signed({8'b0, delta})
			: smooth_q + $signed({8'b0, delta});

		r34    = {{2{ramp_q[31]}}, ramp_q};
		st34   = $signed({2'b0, div_quot[31:0]});
		lo34   = r34 - st34;
		hi34   = r34 + st34;
		t34    = {{10{tgt_q[23]}}, tgt_q};
		ramp_d = (t34 < lo34) ? lo34 : ((t34 > hi34) ? hi34 : t34);

		// The error is multiplied in the cycle that registers it.
		err_d   = $signed(smooth_q[25:0]) - $signed(ramp_q[25:0]);
		err_mag = err_d[25] ? 25'(-err_d) : err_d[24:0];

		inc    = err_q[25] ? -$signed({1'b0, div_quot[47:0]}) : $signed({1'b0, div_quot[47:0]});
		ni_sum = $signed({{2{integ_q[47]}}, integ_q}) + $signed({inc[48], inc});
		ni_sat = (ni_sum > I_MAX) ? I_MAX : ((ni_sum < I_MIN) ? I_MIN : ni_sum);

		x     = cmd.use_old ? integ_q : ni_q;
		x_mag = x[47] ? 48'(-x) : x;
		k_tot = {prod_q[47:0], 24'b0} + {24'b0, plo_q};
		ki    = x[47] ? -$signed({2'b0, k_tot[71:32]}) : $signed({2'b0, k_tot[71:32]});
		s_raw = $signed({{16{err_q[25]}}, err_q}) + ki;
		s_cl  = (s_raw > S_MAX) ? S_MAX : ((s_raw < -S_MAX) ? -S_MAX : s_raw);

		// Current is the negated, magnitude-truncated product of gain and error sum.
		p_tot = {prod_q[38:0], 24'b0} + {15'b0, plo_q};
		p_mag = p_tot[62:16];
		cand  = s_neg_q ? $signed({1'b0, p_mag}) : -$signed({1'b0, p_mag});

		ff10  = ($signed({{4{tgt_q[23]}}, tgt_q}) <<< 3) + ($signed({{4{tgt_q[23]}}, tgt_q}) <<< 1);
		ffl   = $signed({5'b0, ff_limit_q});
		ff    = (ff10 > ffl) ? ffl : ((ff10 < -ffl) ? -ffl : ff10);
		sum49 = $signed({cur_q[47], cur_q}) + $signed({{21{ff[27]}}, ff});
		lim49 = $signed({26'b0, output_limit_q});
		cur_d = (sum49 > lim49) ? lim49 : ((sum49 < -lim49) ? -lim49 : sum49);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MUL_VEL:  begin mul_a = d_mag; mul_b = US_PER_S; end
			OP_MUL_CD:   begin mul_a = {18'b0, cutoff_hz_q}; mul_b = {8'b0, dt_q}; end
			OP_MUL_W:    begin mul_a = {2'b0, prod_q[29:0]}; mul_b = TWO_PI_Q16; end
			OP_MUL_FILT: begin mul_a = {8'b0, diff_mag}; mul_b = div_quot[23:0]; end
			OP_MUL_STEP: begin mul_a = {1'b0, accel_limit_q}; mul_b = {8'b0, dt_q}; end
			OP_MUL_ERR:  begin mul_a = {7'b0, err_mag}; mul_b = {8'b0, dt_q}; end
			OP_MUL_KLO:  begin mul_a = {8'b0, x_mag[23:0]}; mul_b = integ_gain_q; end
			OP_MUL_KHI:  begin mul_a = {8'b0, x_mag[47:24]}; mul_b = integ_gain_q; end
			OP_MUL_PLO:  begin mul_a = {8'b0, s_mag_q[23:0]}; mul_b = prop_gain_q; end
			OP_MUL_PHI:  begin mul_a = {17'b0, s_mag_q[38:24]}; mul_b = prop_gain_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = {10'b0, US_PER_S};
		unique case (cmd.op)
			OP_DIV_RAW: begin
				div_start    = 1'b1;
				div_dividend = {8'b0, prod_q};
				div_divisor  = {18'b0, dt_q};
			end
			OP_DIV_ALPHA: begin
				div_start    = 1'b1;
				div_dividend = {7'b0, w, 24'b0};
				div_divisor  = {10'b0, US_PER_S} + {1'b0, w};
			end
			OP_DIV_STEP: begin
				div_start    = 1'b1;
				div_dividend = {8'b0, prod_q};
			end
			OP_DIV_INC: begin
				div_start    = 1'b1;
				div_dividend = {7'b0, prod_q[40:0], 16'b0};
			end
			default: div_start = 1'b0;
		endcase
	end

	vpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= 24'd65536;
			integ_gain_q   <= '0;
			output_limit_q <= 23'd65536;
			cutoff_hz_q    <= 14'd10;
			ff_limit_q     <= '0;
			accel_limit_q  <= 31'd6553600;
			last_q         <= '0;
			smooth_q       <= '0;
			ramp_q         <= '0;
			integ_q        <= '0;
			stopped_q      <= 1'b0;
			errcnt_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_PROP_GAIN:    prop_gain_q    <= cfg_wdata[23:0];
					REG_INTEG_GAIN:   integ_gain_q   <= cfg_wdata[23:0];
					REG_OUTPUT_LIMIT: output_limit_q <= cfg_wdata[22:0];
					REG_CUTOFF_HZ:    cutoff_hz_q    <= cfg_wdata[13:0];
					REG_FF_LIMIT:     ff_limit_q     <= cfg_wdata[22:0];
					REG_ACCEL_LIMIT:  accel_limit_q  <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (cmd.op)
				OP_LATCH: begin
					if (position_valid) begin
						errcnt_q <= '0;
					end else if (errcnt_q != 16'hFFFF) begin
						errcnt_q <= errcnt_q + 16'd1;
					end
				end
				OP_RAW:  last_q   <= $signed(pos_q);
				OP_FILT: smooth_q <= smooth_d;
				OP_STOP: begin
					ramp_q    <= '0;
					stopped_q <= 1'b1;
				end
				OP_MUL_STEP: begin
					if (stopped_q) begin
						integ_q <= '0;
						ramp_q  <= '0;
					end
				end
				OP_RAMP: ramp_q <= ramp_d[31:0];
				OP_PSUM: begin
					if (!cmd.use_old && (p_mag < {24'b0, output_limit_q})) begin
						integ_q <= ni_q;
					end
				end
				OP_FF: stopped_q <= 1'b0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (cmd.op)
			OP_LATCH: begin
				func_q  <= func;
				valid_q <= position_valid;
				pos_q   <= measured_position;
				dt_q    <= (step_time_us == 16'd0) ? 16'd1 : step_time_us;
				tgt_q   <= $signed(target_velocity);
				d_q     <= d_in;
			end
			OP_RAW:      raw_q <= raw_d;
			OP_MUL_FILT: diff_neg_q <= diff[24];
			OP_STOP:     cur_q <= '0;
			OP_MUL_ERR:  err_q <= err_d;
			OP_NI:       ni_q <= ni_sat[47:0];
			OP_MUL_KHI:  plo_q <= prod_q[47:0];
			OP_KSUM: begin
				s_neg_q <= s_cl[41];
				s_mag_q <= s_cl[41] ? 39'(-s_cl) : s_cl[38:0];
			end
			OP_MUL_PHI:  plo_q <= prod_q[47:0];
			OP_PSUM:     cur_q <= cand;
			OP_FF:       cur_q <= cur_d[47:0];
			OP_OUT: begin
				drive_current     <= cur_q[23:0];
				filtered_velocity <= smooth_q[23:0];
				stop_command      <= func_q;
				comm_errors       <= errcnt_q;
			end
			default: ;
		endcase
	end

	assign stat.pos_valid = valid_q;
	assign stat.stop      = func_q;
	assign stat.div_done  = div_done;
	assign stat.cand_ok   = (p_mag < {24'b0, output_limit_q});
endmodule
`default_nettype wire

// File: hdl/velocity_pi_controller_top.sv
// Velocity PI controller with acceleration ramp, anti-windup and feedforward.
// A stop step with a failed position read is the shortest item, and a run step
// with a valid read whose first PI candidate saturates is the longest. The
// duration is set by the shared divider, with up to four divisions per item,
// and by the single 32x24 multiplier that all products share.
// One item is worked on at a time; the next is accepted once its result is queued.
// Depends on vpc_pkg, vpc_ctrl, vpc_dp and vpc_div.
`default_nettype none
module velocity_pi_controller_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [vpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [vpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// measured_position [31:0], step_time_us [47:32], target_velocity [71:48]
	input  wire logic [71:0]                    s_tdata,
	// func [0], position_valid [1]
	input  wire logic [1:0]                     s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// drive_current [23:0], filtered_velocity [47:24], comm_errors [63:48]
	output logic [63:0]                         m_tdata,
	// stop_command [0]
	output logic                                m_tuser
);
	import vpc_pkg::*;

	vpc_cmd_t    cmd;
	vpc_stat_t   stat;
	logic [23:0] drive_current, filtered_velocity;
	logic [15:0] comm_errors;

	vpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vpc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.func              (s_tuser[0]),
		.measured_position (s_tdata[31:0]),
		.position_valid    (s_tuser[1]),
		.step_time_us      (s_tdata[47:32]),
		.target_velocity   (s_tdata[71:48]),
		.cmd               (cmd),
		.stat              (stat),
		.drive_current     (drive_current),
		.filtered_velocity (filtered_velocity),
		.stop_command      (m_tuser),
		.comm_errors       (comm_errors)
	);

	assign m_tdata = {comm_errors, filtered_velocity, drive_current};

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while one is in work");

	// A stop step always drives zero current.
	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[23:0] == 24'd0)
		else $error("stop result with nonzero current");

	// A divider result only arrives while the sequencer waits and issues no command.
	a_div_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> cmd.op == OP_NOP)
		else $error("divider finished outside a wait state");
endmodule
`default_nettype wire
